FILE: src/ncrf_pkg.sv
// Package for the neighbor count relabel filter.
// Holds widths, register indexes, reset values and the window edge type.
// No dependencies.
package ncrf_pkg;

   localparam int MAX_LINE_DEF = 1024;
   localparam int MAX_ROWS     = 1024;

   localparam int PIX_W      = 8;
   localparam int THR_W      = 4;
   localparam int GEOM_W     = 11;
   localparam int ROW_W      = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_GROW_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLBACK  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 3'd5;

   localparam logic [PIX_W-1:0]  TARGET_RST    = 8'd250;
   localparam logic [PIX_W-1:0]  FALLBACK_RST  = 8'd150;
   localparam logic [THR_W-1:0]  THRESHOLD_RST = 4'd5;
   localparam logic [GEOM_W-1:0] GEOM_RST      = 11'd1024;

   typedef struct packed {
      logic emit;
      logic last;
      logic cr_first;
      logic cr_last;
      logic cc_first;
      logic cc_last;
   } ctx_type;

endpackage

FILE: src/ncrf_line_buffer.sv
// Two line memories (upper and middle row) with registered read and
// write-to-read bypass for back-to-back requests at the same column.
// Depends on ncrf_pkg.
module ncrf_line_buffer #(
   parameter int MAX_LINE = ncrf_pkg::MAX_LINE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_LINE)-1:0]   rd_addr,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_LINE)-1:0]   wr_addr,
   input  logic [ncrf_pkg::PIX_W-1:0]    wr_upper,
   input  logic [ncrf_pkg::PIX_W-1:0]    wr_middle,
   output logic [ncrf_pkg::PIX_W-1:0]    top,
   output logic [ncrf_pkg::PIX_W-1:0]    mid
);

   logic [ncrf_pkg::PIX_W-1:0] upper_mem  [MAX_LINE];
   logic [ncrf_pkg::PIX_W-1:0] middle_mem [MAX_LINE];

   logic [ncrf_pkg::PIX_W-1:0] upper_rd_ff;
   logic [ncrf_pkg::PIX_W-1:0] middle_rd_ff;
   logic                       byp_ff;
   logic                       byp_in;
   logic [ncrf_pkg::PIX_W-1:0] byp_upper_ff;
   logic [ncrf_pkg::PIX_W-1:0] byp_middle_ff;

   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= wr_upper;
         middle_mem[wr_addr] <= wr_middle;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         upper_rd_ff   <= upper_mem[rd_addr];
         middle_rd_ff  <= middle_mem[rd_addr];
         byp_upper_ff  <= wr_upper;
         byp_middle_ff <= wr_middle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= byp_in;
      end
   end

   assign top = byp_ff ? byp_upper_ff  : upper_rd_ff;
   assign mid = byp_ff ? byp_middle_ff : middle_rd_ff;

endmodule

FILE: src/neighbor_count_relabel_filter.sv
// Result path: the request that completes a window is held in stage one; its result is registered
// when stage one advances. The window centre trails the request stream by frame_width+1 requests.
// Throughput: one request per cycle unless stalled, limited by each line memory's read/write port.
// Reset: position, window and output valid clear; registers return to their defaults.
// Line memories are not cleared and need no clearing pass.
// Depends on ncrf_pkg and ncrf_line_buffer.
module neighbor_count_relabel_filter #(
   parameter int MAX_LINE = ncrf_pkg::MAX_LINE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ncrf_pkg::PIX_W-1:0]         req_pixel_in,
   input  logic                               req_is_flush,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ncrf_pkg::PIX_W-1:0]         rsp_pixel_out,
   output logic                               rsp_frame_end,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ncrf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ncrf_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW = $clog2(MAX_LINE + 1);
   localparam int IW = $clog2(MAX_LINE);
   localparam int XW = (CW > ncrf_pkg::GEOM_W) ? CW : ncrf_pkg::GEOM_W;
   localparam int RW = ncrf_pkg::ROW_W;
   localparam int PW = ncrf_pkg::PIX_W;

   // configuration
   logic                        grow_mode_ff;
   logic [PW-1:0]               target_ff;
   logic [PW-1:0]               fallback_ff;
   logic [ncrf_pkg::THR_W-1:0]  threshold_ff;
   logic [ncrf_pkg::GEOM_W-1:0] frame_width_ff;
   logic [ncrf_pkg::GEOM_W-1:0] frame_height_ff;
   logic                        csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grow_mode_ff    <= 1'b0;
         target_ff       <= ncrf_pkg::TARGET_RST;
         fallback_ff     <= ncrf_pkg::FALLBACK_RST;
         threshold_ff    <= ncrf_pkg::THRESHOLD_RST;
         frame_width_ff  <= ncrf_pkg::GEOM_RST;
         frame_height_ff <= ncrf_pkg::GEOM_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            ncrf_pkg::CSR_GROW_MODE: grow_mode_ff    <= csr_data[0];
            ncrf_pkg::CSR_TARGET:    target_ff       <= csr_data[PW-1:0];
            ncrf_pkg::CSR_FALLBACK:  fallback_ff     <= csr_data[PW-1:0];
            ncrf_pkg::CSR_THRESHOLD: threshold_ff    <= csr_data[ncrf_pkg::THR_W-1:0];
            ncrf_pkg::CSR_WIDTH:     frame_width_ff  <= csr_data;
            ncrf_pkg::CSR_HEIGHT:    frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // clamped geometry
   logic [XW-1:0] fw_x;
   logic [XW-1:0] w_x;
   logic [CW-1:0] w;
   logic [RW-1:0] h;
   logic [RW-1:0] h_p1;
   logic [RW-1:0] h_m1;

   assign fw_x = XW'(frame_width_ff);
   assign w_x  = (fw_x < XW'(3)) ? XW'(3) :
                 (fw_x > XW'(MAX_LINE)) ? XW'(MAX_LINE) : fw_x;
   assign w    = CW'(w_x);
   assign h    = (frame_height_ff < RW'(3)) ? RW'(3) :
                 (frame_height_ff > RW'(ncrf_pkg::MAX_ROWS)) ? RW'(ncrf_pkg::MAX_ROWS) :
                 RW'(frame_height_ff);
   assign h_p1 = h + RW'(1);
   assign h_m1 = h - RW'(1);

   // request position
   logic [CW-1:0] column_pos_ff, column_pos_in;
   logic [RW-1:0] row_pos_ff, row_pos_in;
   logic          wrap_a;
   logic [CW-1:0] col_b;
   logic [RW-1:0] row_b;
   logic          restart;
   logic [CW-1:0] col;
   logic [RW-1:0] row;
   logic [CW-1:0] col_inc;
   logic [RW-1:0] cr;
   logic          pre_emit;
   ncrf_pkg::ctx_type ctx_in;
   logic [PW-1:0] pix_in;
   logic          accept;

   // stage one
   logic              s1_valid_ff;
   logic [IW-1:0]     s1_col_ff;
   logic [PW-1:0]     s1_pixel_ff;
   ncrf_pkg::ctx_type s1_ctx_ff;
   logic              s1_adv;
   logic              out_free;

   assign wrap_a  = column_pos_ff >= w;
   assign col_b   = wrap_a ? '0 : column_pos_ff;
   assign row_b   = wrap_a ? row_pos_ff + RW'(1) : row_pos_ff;
   assign restart = row_b > h_p1;
   assign col     = restart ? '0 : col_b;
   assign row     = restart ? '0 : row_b;
   assign col_inc = col + CW'(1);

   assign pre_emit = (row >= RW'(2)) || ((row == RW'(1)) && (col != '0));
   assign cr       = (col != '0) ? row - RW'(1) : row - RW'(2);

   assign ctx_in.emit     = pre_emit && (cr < h);
   assign ctx_in.last     = ctx_in.emit && (cr == h_m1) && (col == '0);
   assign ctx_in.cr_first = cr == '0;
   assign ctx_in.cr_last  = cr == h_m1;
   assign ctx_in.cc_first = col == CW'(1);
   assign ctx_in.cc_last  = col == '0;

   assign pix_in = (req_is_flush || (row >= h)) ? '0 : req_pixel_in;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign s1_adv    = s1_valid_ff && (!s1_ctx_ff.emit || out_free);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      column_pos_in = column_pos_ff;
      row_pos_in    = row_pos_ff;
      if (accept) begin
         if (ctx_in.last) begin
            column_pos_in = '0;
            row_pos_in    = '0;
         end else if (col_inc >= w) begin
            column_pos_in = '0;
            row_pos_in    = row + RW'(1);
         end else begin
            column_pos_in = col_inc;
            row_pos_in    = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff <= '0;
         row_pos_ff    <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         column_pos_ff <= column_pos_in;
         row_pos_ff    <= row_pos_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= col[IW-1:0];
         s1_pixel_ff <= pix_in;
         s1_ctx_ff   <= ctx_in;
      end
   end

   // line memories
   logic [PW-1:0] top;
   logic [PW-1:0] mid;

   ncrf_line_buffer #(
      .MAX_LINE (MAX_LINE)
   ) u_line_buffer (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (col[IW-1:0]),
      .wr_en     (s1_adv),
      .wr_addr   (s1_col_ff),
      .wr_upper  (mid),
      .wr_middle (s1_pixel_ff),
      .top       (top),
      .mid       (mid)
   );

   // window: column 0 is the older, column 1 the newer stored column
   logic [PW-1:0] win_ff [3][2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= '0;
            win_ff[r][1] <= '0;
         end
      end else if (s1_adv) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
         end
         win_ff[0][1] <= top;
         win_ff[1][1] <= mid;
         win_ff[2][1] <= s1_pixel_ff;
      end
   end

   // neighbor count and relabel
   logic [7:0]    hit;
   logic [3:0]    cnt;
   logic [PW-1:0] centre;
   logic [PW-1:0] result;

   assign hit[0] = !s1_ctx_ff.cr_first && !s1_ctx_ff.cc_first && (win_ff[0][0] == target_ff);
   assign hit[1] = !s1_ctx_ff.cr_first && (win_ff[0][1] == target_ff);
   assign hit[2] = !s1_ctx_ff.cr_first && !s1_ctx_ff.cc_last && (top == target_ff);
   assign hit[3] = !s1_ctx_ff.cc_first && (win_ff[1][0] == target_ff);
   assign hit[4] = !s1_ctx_ff.cc_last && (mid == target_ff);
   assign hit[5] = !s1_ctx_ff.cr_last && !s1_ctx_ff.cc_first && (win_ff[2][0] == target_ff);
   assign hit[6] = !s1_ctx_ff.cr_last && (win_ff[2][1] == target_ff);
   assign hit[7] = !s1_ctx_ff.cr_last && !s1_ctx_ff.cc_last && (s1_pixel_ff == target_ff);

   assign cnt    = 4'($countones(hit));
   assign centre = win_ff[1][1];

   always_comb begin
      result = centre;
      if (!grow_mode_ff) begin
         if ((centre == target_ff) && (cnt < threshold_ff)) begin
            result = fallback_ff;
         end
      end else begin
         if ((centre == fallback_ff) && (cnt >= threshold_ff)) begin
            result = target_ff;
         end
      end
   end

   // result register
   logic          rsp_valid_ff;
   logic [PW-1:0] rsp_pixel_ff;
   logic          rsp_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_ctx_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_ctx_ff.emit) begin
         rsp_pixel_ff     <= result;
         rsp_frame_end_ff <= s1_ctx_ff.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // checks
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with stage one empty");

   a_frame_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && ctx_in.last) |=> ((column_pos_ff == '0) && (row_pos_ff == '0)))
      else $error("position not restarted after frame end");

   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      (column_pos_ff <= CW'(MAX_LINE)))
      else $error("column position beyond line length");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_adv && s1_ctx_ff.emit))
      else $error("result appeared without a stage one advance");

endmodule

FILE: tb/sv/neighbor_count_relabel_filter_tb.sv
// Self-checking testbench for neighbor_count_relabel_filter: streams label frames, predicts
// each filtered pixel from a behavioral copy of the line buffers and window, and checks results.
// Depends on ncrf_pkg and the filter RTL.
module neighbor_count_relabel_filter_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PW          = ncrf_pkg::PIX_W;
   localparam int TW          = ncrf_pkg::THR_W;
   localparam int GW          = ncrf_pkg::GEOM_W;
   localparam int IXW         = ncrf_pkg::CSR_IDX_W;
   localparam int DW          = ncrf_pkg::CSR_DATA_W;
   localparam int LINE_LEN    = ncrf_pkg::MAX_LINE_DEF;

   typedef struct packed {
      logic [PW-1:0] pixel;
      logic          frame_end;
   } label_result_type;

   logic           clock;
   logic           reset        = 1'b1;
   logic           req_valid    = 1'b0;
   logic           req_stall;
   logic [PW-1:0]  req_pixel_in = '0;
   logic           req_is_flush = 1'b0;
   logic           rsp_valid;
   logic           rsp_stall    = 1'b0;
   logic [PW-1:0]  rsp_pixel_out;
   logic           rsp_frame_end;
   logic           csr_valid    = 1'b0;
   logic           csr_ready;
   logic [IXW-1:0] csr_index    = '0;
   logic [DW-1:0]  csr_data     = '0;

   // behavioral copy of the filter state and registers
   logic [PW-1:0]  line_upper [0:LINE_LEN-1];
   logic [PW-1:0]  line_middle [0:LINE_LEN-1];
   logic [PW-1:0]  win [0:2][0:2];
   int unsigned    col_pos = 0;
   int unsigned    row_pos = 0;
   logic           cfg_grow      = 1'b0;
   logic [PW-1:0]  cfg_target    = ncrf_pkg::TARGET_RST;
   logic [PW-1:0]  cfg_fallback  = ncrf_pkg::FALLBACK_RST;
   logic [TW-1:0]  cfg_threshold = ncrf_pkg::THRESHOLD_RST;
   logic [GW-1:0]  cfg_width     = ncrf_pkg::GEOM_RST;
   logic [GW-1:0]  cfg_height    = ncrf_pkg::GEOM_RST;

   label_result_type expected_pixels [$];
   int               errors        = 0;
   int               requests_sent = 0;
   int               cycle_count   = 0;
   bit               calm          = 1'b0;

   neighbor_count_relabel_filter dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_in  (req_pixel_in),
      .req_is_flush  (req_is_flush),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned clamp_geom(input logic [GW-1:0] v, input int unsigned hi);
      if (v < GW'(3)) return 3;
      if (32'(v) > hi) return hi;
      return 32'(v);
   endfunction

   function automatic bit relabel_step(input logic [PW-1:0] pix, input logic flush,
                                       output logic [PW-1:0] res, output logic last);
      int unsigned w, h, col, row, cr, cc, cnt;
      int r, c;
      logic [PW-1:0] p, top, mid, centre;
      w = clamp_geom(cfg_width, LINE_LEN);
      h = clamp_geom(cfg_height, ncrf_pkg::MAX_ROWS);
      res = '0;
      last = 1'b0;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos > h + 1) begin
         row_pos = 0;
         col_pos = 0;
      end
      col = col_pos;
      row = row_pos;
      p = (flush || row >= h) ? '0 : pix;
      top = line_upper[col];
      mid = line_middle[col];
      line_upper[col] = mid;
      line_middle[col] = p;
      for (r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = p;
      col_pos = col + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = row + 1;
      end
      if (!(row >= 2 || (row == 1 && col >= 1))) return 1'b0;
      if (col >= 1) begin
         cr = row - 1;
         cc = col - 1;
      end else begin
         cr = row - 2;
         cc = w - 1;
      end
      if (cr >= h) return 1'b0;
      cnt = 0;
      for (r = 0; r < 3; r++) begin
         for (c = 0; c < 3; c++) begin
            if ((r == 0 && cr == 0) || (r == 2 && cr == h - 1) || (r == 1 && c == 1) ||
                (c == 0 && cc == 0) || (c == 2 && cc == w - 1))
               continue;
            if (win[r][c] == cfg_target) cnt++;
         end
      end
      centre = win[1][1];
      res = centre;
      if (!cfg_grow) begin
         if (centre == cfg_target && cnt < cfg_threshold) res = cfg_fallback;
      end else if (centre == cfg_fallback && cnt >= cfg_threshold) begin
         res = cfg_target;
      end
      last = (cr == h - 1 && cc == w - 1);
      if (last) begin
         col_pos = 0;
         row_pos = 0;
      end
      return 1'b1;
   endfunction

   function automatic logic [PW-1:0] pick_label();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return cfg_target;
      if (sel < 7) return cfg_fallback;
      return PW'($urandom_range(0, 255));
   endfunction

   task automatic send_request(input logic [PW-1:0] pix, input logic flush);
      label_result_type r;
      logic [PW-1:0] res;
      logic last;
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      req_is_flush <= flush;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      if (relabel_step(pix, flush, res, last)) begin
         r.pixel = res;
         r.frame_end = last;
         expected_pixels.push_back(r);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IXW-1:0] idx, input logic [DW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ncrf_pkg::CSR_GROW_MODE: cfg_grow      = data[0];
         ncrf_pkg::CSR_TARGET:    cfg_target    = data[PW-1:0];
         ncrf_pkg::CSR_FALLBACK:  cfg_fallback  = data[PW-1:0];
         ncrf_pkg::CSR_THRESHOLD: cfg_threshold = data[TW-1:0];
         ncrf_pkg::CSR_WIDTH:     cfg_width     = data[GW-1:0];
         ncrf_pkg::CSR_HEIGHT:    cfg_height    = data[GW-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper data bits carry random values
   task automatic set_labels(input logic grow, input logic [PW-1:0] target,
                             input logic [PW-1:0] fallback, input logic [TW-1:0] thr);
      logic [DW-1:0] d;
      d = DW'($urandom);
      d[0] = grow;
      write_reg(ncrf_pkg::CSR_GROW_MODE, d);
      d = DW'($urandom);
      d[PW-1:0] = target;
      write_reg(ncrf_pkg::CSR_TARGET, d);
      d = DW'($urandom);
      d[PW-1:0] = fallback;
      write_reg(ncrf_pkg::CSR_FALLBACK, d);
      d = DW'($urandom);
      d[TW-1:0] = thr;
      write_reg(ncrf_pkg::CSR_THRESHOLD, d);
   endtask

   task automatic set_geometry(input logic [GW-1:0] w, input logic [GW-1:0] h);
      write_reg(ncrf_pkg::CSR_WIDTH, w);
      write_reg(ncrf_pkg::CSR_HEIGHT, h);
   endtask

   // one frame of pixels followed by the drain padding
   task automatic send_frame(input int noise_pct, input int pause_at);
      int w, h, n;
      w = clamp_geom(cfg_width, LINE_LEN);
      h = clamp_geom(cfg_height, ncrf_pkg::MAX_ROWS);
      for (n = 0; n < w * h + w + 1; n++) begin
         if (n == pause_at) wait_idle();
         if (n < w * h) begin
            if ($urandom_range(0, 99) < noise_pct)
               send_request(PW'($urandom_range(0, 255)), 1'b1);
            else
               send_request(pick_label(), 1'b0);
         end else begin
            send_request(PW'($urandom_range(0, 255)), $urandom_range(0, 99) >= noise_pct);
         end
      end
   endtask

   task automatic test_reset_values();
      set_geometry(11'd3, 11'd3);
      send_frame(0, -1);
      send_frame(0, -1);
      wait_idle();
   endtask

   task automatic test_directed_cases();
      logic [PW-1:0] seq_pix [0:25];
      logic          seq_flush [0:25];
      int n;
      seq_pix   = '{8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd7, 8'd255, 8'd255,
                    8'd255, 8'hAA, 8'd0, 8'h55,
                    8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd1, 8'd0, 8'd255, 8'd254,
                    8'd255, 8'd0, 8'hFF, 8'h01};
      seq_flush = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 1,
                    0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1};
      set_geometry(11'd3, 11'd3);
      set_labels(1'b0, 8'd255, 8'd0, 4'd8);
      for (n = 0; n < 26; n++) begin
         if (n == 13) begin
            wait_idle();
            set_labels(1'b1, 8'd0, 8'd255, 4'd0);
         end
         send_request(seq_pix[n], seq_flush[n]);
      end
      wait_idle();
   endtask

   task automatic test_thresholds();
      int g, k;
      int thr_list [0:6];
      thr_list = '{0, 1, 4, 5, 8, 9, 15};
      set_geometry(11'd4, 11'd4);
      for (g = 0; g < 2; g++) begin
         for (k = 0; k < 7; k++) begin
            set_labels(g[0], PW'($urandom_range(0, 255)), PW'($urandom_range(0, 255)),
                       TW'(thr_list[k]));
            send_frame(0, -1);
            wait_idle();
         end
      end
   endtask

   task automatic test_geometry_extremes();
      set_labels(1'($urandom_range(0, 1)), PW'($urandom_range(0, 255)),
                 PW'($urandom_range(0, 255)), TW'($urandom_range(0, 8)));
      set_geometry(11'd0, 11'd0);
      send_frame(5, -1);
      wait_idle();
      set_geometry(11'd2, 11'd1);
      send_frame(5, -1);
      wait_idle();
   endtask

   task automatic test_random_frames();
      int start, frames;
      start = requests_sent;
      frames = 0;
      while (requests_sent - start < 230) begin
         if (frames == 0 || $urandom_range(0, 1)) begin
            wait_idle();
            set_labels(1'($urandom_range(0, 1)), PW'($urandom_range(0, 255)),
                       PW'($urandom_range(0, 255)), TW'($urandom_range(0, 15)));
            if ($urandom_range(0, 9) == 0)
               set_geometry(GW'($urandom_range(11, 40)), GW'($urandom_range(3, 8)));
            else
               set_geometry(GW'($urandom_range(3, 10)), GW'($urandom_range(3, 6)));
         end
         calm = (frames >= 2 && frames < 5);
         send_frame(8, (frames == 1) ? int'($urandom_range(1, 10)) : -1);
         frames++;
      end
      calm = 1'b0;
      wait_idle();
   endtask

   always @(posedge clock) begin : check_results
      label_result_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result, expected none actual pixel_out=%0d frame_end=%0b",
                     $time, rsp_pixel_out, rsp_frame_end);
            errors++;
         end else begin
            expected = expected_pixels.pop_front();
            if (rsp_pixel_out !== expected.pixel) begin
               $display("%0t: pixel_out mismatch, expected %0d actual %0d",
                        $time, expected.pixel, rsp_pixel_out);
               errors++;
            end
            if (rsp_frame_end !== expected.frame_end) begin
               $display("%0t: frame_end mismatch, expected %0b actual %0b",
                        $time, expected.frame_end, rsp_frame_end);
               errors++;
            end
         end
      end
      rsp_stall <= !calm && ($urandom_range(0, 99) < 7);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < LINE_LEN; i++) begin
         line_upper[i]  = '0;
         line_middle[i] = '0;
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            win[r][c] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed_cases();
      test_thresholds();
      test_geometry_extremes();
      test_random_frames();
      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: files.f
src/ncrf_pkg.sv
src/ncrf_line_buffer.sv
src/neighbor_count_relabel_filter.sv
tb/sv/neighbor_count_relabel_filter_tb.sv
